// ===== src/ddo_pkg.sv =====
// Shared constants, types and helpers for the differential-drive odometry block.
// No dependencies. Imported by ddo_div, ddo_cordic and diff_drive_odometry.
package ddo_pkg;

    localparam int CORDIC_STEPS  = 14;
    localparam int CORDIC_IDX_W  = $clog2(CORDIC_STEPS);
    localparam int ATAN_ENTRIES  = 24;

    localparam int DIV_NUM_W     = 52;
    localparam int DIV_DEN_W     = 16;
    localparam int DIV_RADIX     = 4;
    localparam int DIV_STEPS     = DIV_NUM_W / DIV_RADIX;
    localparam int DIV_CNT_W     = $clog2(DIV_STEPS);

    localparam logic signed [15:0] PI_Q      = 16'sd12868;
    localparam logic signed [15:0] HALF_PI_Q = 16'sd6434;
    localparam logic signed [15:0] TWO_PI_Q  = 16'sd25736;
    localparam logic signed [32:0] CORDIC_GAIN_Q30 = 33'sd652032874;

    typedef logic signed [17:0] trig_t;

    typedef enum logic [2:0] {
        REG_WHEEL_RADIUS = 3'd0,
        REG_WHEEL_BASE   = 3'd1,
        REG_SLIP_FACTOR  = 3'd2,
        REG_STRAIGHT_THR = 3'd3,
        REG_PATH_STEP    = 3'd4,
        REG_DRIFT_X      = 3'd5,
        REG_DRIFT_Y      = 3'd6
    } cfg_idx_t;

    function automatic logic signed [31:0] atan_q28(input logic [4:0] idx);
        logic signed [31:0] v;
        case (idx)
            5'd0:    v = 32'sd210828714;
            5'd1:    v = 32'sd124459456;
            5'd2:    v = 32'sd65760959;
            5'd3:    v = 32'sd33381290;
            5'd4:    v = 32'sd16755422;
            5'd5:    v = 32'sd8385879;
            5'd6:    v = 32'sd4193963;
            5'd7:    v = 32'sd2097109;
            5'd8:    v = 32'sd1048571;
            5'd9:    v = 32'sd524287;
            5'd10:   v = 32'sd262144;
            5'd11:   v = 32'sd131072;
            5'd12:   v = 32'sd65536;
            5'd13:   v = 32'sd32768;
            5'd14:   v = 32'sd16384;
            5'd15:   v = 32'sd8192;
            5'd16:   v = 32'sd4096;
            5'd17:   v = 32'sd2048;
            5'd18:   v = 32'sd1024;
            5'd19:   v = 32'sd512;
            5'd20:   v = 32'sd256;
            5'd21:   v = 32'sd128;
            5'd22:   v = 32'sd64;
            5'd23:   v = 32'sd32;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

    // arithmetic right shift by k, rounding to nearest, ties away from zero
    function automatic logic signed [55:0] rnd_shr(input logic signed [55:0] v,
                                                   input int unsigned k);
        logic [55:0] m;
        logic [55:0] q;
        m = v[55] ? 56'(-v) : 56'(v);
        q = (m + (56'd1 << (k - 1))) >> k;
        return v[55] ? -$signed(q) : $signed(q);
    endfunction

endpackage

// ===== src/ddo_div.sv =====
// Unsigned restoring divider, four quotient bits per cycle.
// Depends on ddo_pkg for operand widths.
module ddo_div import ddo_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] num,
    input  logic [DIV_DEN_W-1:0] den,
    output logic                 busy,
    output logic [DIV_NUM_W-1:0] quot
);

    logic                 busy_reg, busy_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_NUM_W-1:0] acc_reg, acc_next;
    logic [DIV_DEN_W:0]   rem_reg, rem_next;
    logic [DIV_DEN_W-1:0] den_reg;

    always_comb begin
        logic [DIV_DEN_W:0]   r;
        logic [DIV_NUM_W-1:0] a;
        r = rem_reg;
        a = acc_reg;
        for (int j = 0; j < DIV_RADIX; j++) begin
            r = {r[DIV_DEN_W-1:0], a[DIV_NUM_W-1]};
            a = {a[DIV_NUM_W-2:0], 1'b0};
            if (r >= {1'b0, den_reg}) begin
                r    = r - {1'b0, den_reg};
                a[0] = 1'b1;
            end
        end
        rem_next  = r;
        acc_next  = a;
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end else if (busy_reg) begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end else if (busy_reg) begin
            acc_reg <= acc_next;
            rem_reg <= rem_next;
        end
    end

    assign busy = busy_reg;
    assign quot = acc_reg;

endmodule

// ===== src/ddo_cordic.sv =====
// Rotation-mode CORDIC, one micro-rotation per cycle, Q3.12 angle in, Q16 cos/sin out.
// Depends on ddo_pkg for the arctangent table and step count.
module ddo_cordic import ddo_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [14:0] angle,
    output logic               busy,
    output trig_t              cos_out,
    output trig_t              sin_out
);

    logic                    busy_reg;
    logic [CORDIC_IDX_W-1:0] idx_reg;
    logic signed [32:0]      x_reg, x_next;
    logic signed [32:0]      y_reg, y_next;
    logic signed [31:0]      z_reg, z_next;
    logic                    flip_reg;
    logic signed [15:0]      ang_ext, ang_fold;
    logic                    flip_w;
    logic signed [55:0]      xr, yr;

    always_comb begin
        ang_ext = {angle[14], angle};
        flip_w  = 1'b0;
        ang_fold = ang_ext;
        if (ang_ext > HALF_PI_Q) begin
            ang_fold = ang_ext - PI_Q;
            flip_w   = 1'b1;
        end else if (ang_ext < -HALF_PI_Q) begin
            ang_fold = ang_ext + PI_Q;
            flip_w   = 1'b1;
        end
    end

    always_comb begin
        logic signed [32:0] xs, ys;
        logic signed [31:0] at;
        xs = x_reg >>> idx_reg;
        ys = y_reg >>> idx_reg;
        at = atan_q28(5'(idx_reg));
        if (!z_reg[31]) begin
            x_next = x_reg - ys;
            y_next = y_reg + xs;
            z_next = z_reg - at;
        end else begin
            x_next = x_reg + ys;
            y_next = y_reg - xs;
            z_next = z_reg + at;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end else if (busy_reg) begin
            idx_reg <= idx_reg + 1'b1;
            if (idx_reg == CORDIC_IDX_W'(CORDIC_STEPS - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg    <= CORDIC_GAIN_Q30;
            y_reg    <= '0;
            z_reg    <= {ang_fold, 16'b0};
            flip_reg <= flip_w;
        end else if (busy_reg) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign xr = rnd_shr(56'(x_reg), 14);
    assign yr = rnd_shr(56'(y_reg), 14);
    assign cos_out = flip_reg ? -trig_t'(xr) : trig_t'(xr);
    assign sin_out = flip_reg ? -trig_t'(yr) : trig_t'(yr);
    assign busy    = busy_reg;

endmodule

// ===== src/diff_drive_odometry.sv =====
// Differential-drive arc odometry: pose tracking with periodic drift correction.
// Depends on ddo_pkg, ddo_div and ddo_cordic.
//
//  channel  | direction | handshake         | payload
//  ---------+-----------+-------------------+------------------------------------------
//  s_*      | in        | s_valid / s_ready | mode, left_delta, right_delta, centre_distance
//  m_*      | out       | m_valid / m_ready | pos_x, pos_y, heading, was_corrected
//  cfg_*    | in        | cfg_we            | cfg_index, cfg_wdata
//
// One transaction at a time; s_ready is high only while the sequencer is idle.
// Mode 1 runs the drift-correction step. Mode 0 runs one divide, overlapped with a CORDIC
// of the current heading; an arc then adds two more divides and the heading-change CORDIC,
// which overlaps the first arc steps on the shared multiplier sequence.
// A stalled result holds the sequencer in its final step; synchronous active-low reset.
module diff_drive_odometry import ddo_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_mode,
    input  logic signed [15:0] s_left_delta,
    input  logic signed [15:0] s_right_delta,
    input  logic signed [31:0] s_centre_distance,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_pos_x,
    output logic signed [31:0] m_pos_y,
    output logic signed [14:0] m_heading,
    output logic               m_was_corrected,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [30:0]        cfg_wdata
);

    typedef enum logic [22:0] {
        S_IDLE = 23'd1 << 0,
        S_M1   = 23'd1 << 1,
        S_M2   = 23'd1 << 2,
        S_D1   = 23'd1 << 3,
        S_D1W  = 23'd1 << 4,
        S_ST1  = 23'd1 << 5,
        S_ST2  = 23'd1 << 6,
        S_ST3  = 23'd1 << 7,
        S_ST4  = 23'd1 << 8,
        S_ST5  = 23'd1 << 9,
        S_A1   = 23'd1 << 10,
        S_A2   = 23'd1 << 11,
        S_A3   = 23'd1 << 12,
        S_A4   = 23'd1 << 13,
        S_A5   = 23'd1 << 14,
        S_A6   = 23'd1 << 15,
        S_A7   = 23'd1 << 16,
        S_A8   = 23'd1 << 17,
        S_A9   = 23'd1 << 18,
        S_A10  = 23'd1 << 19,
        S_A11  = 23'd1 << 20,
        S_CORR = 23'd1 << 21,
        S_FIN  = 23'd1 << 22
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [15:0]        radius_reg, base_reg, slip_reg;
    logic [14:0]        thr_reg;
    logic [30:0]        step_reg;
    logic signed [15:0] drift_x_reg, drift_y_reg;

    // pose
    logic signed [31:0] pose_x_reg, pose_y_reg;
    logic signed [14:0] heading_reg;
    logic signed [31:0] last_dist_reg;
    logic               seen_reg;
    logic               m_valid_reg;

    // working registers
    logic signed [16:0] diff_reg, sum_reg;
    logic [15:0]        adiff_reg;
    logic signed [31:0] cdist_reg;
    logic signed [14:0] dth_reg;
    logic               hit_reg;
    trig_t              ch_reg, sh_reg;
    logic signed [20:0] dist_reg;
    logic signed [34:0] n2_reg;
    logic signed [35:0] bx_reg, by_reg;
    logic               neg_reg;
    logic signed [55:0] prod_reg, t1_reg;
    logic signed [31:0] dx_reg, dy_reg;

    logic signed [35:0] mul_a;
    logic signed [19:0] mul_b;
    logic signed [55:0] prod_w;

    logic [15:0]        base_eff;
    logic               accept, out_free;

    logic                 div_start, div_busy;
    logic [DIV_NUM_W-1:0] div_num, div_quot;
    logic [DIV_DEN_W-1:0] div_den;

    logic               cor_start, cor_busy;
    logic signed [14:0] cor_angle;
    trig_t              cor_cos, cor_sin;

    logic [35:0]        mag;
    logic               straight;
    logic signed [14:0] dth_w;
    logic [55:0]        prod_abs;
    logic signed [35:0] qdiv17;
    logic signed [32:0] dist_gap;
    logic               corr_hit;
    logic signed [15:0] head_sum, head_wrap;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign out_free = !m_valid_reg || m_ready;
    assign base_eff = (base_reg == 16'd0) ? 16'd1 : base_reg;

    assign prod_w   = mul_a * mul_b;
    assign prod_abs = prod_reg[55] ? 56'(-prod_reg) : 56'(prod_reg);

    // heading change from the first division
    always_comb begin
        logic [14:0] mag_sat;
        mag      = div_quot[DIV_NUM_W-1:16];
        straight = (mag < {21'b0, thr_reg}) || (diff_reg == 17'sd0);
        mag_sat  = (mag > 36'(PI_Q)) ? 15'(PI_Q) : mag[14:0];
        dth_w    = diff_reg[16] ? -$signed(mag_sat) : $signed(mag_sat);
    end

    assign qdiv17 = neg_reg ? -$signed({1'b0, div_quot[DIV_NUM_W-1:17]})
                            : $signed({1'b0, div_quot[DIV_NUM_W-1:17]});

    assign dist_gap = {cdist_reg[31], cdist_reg} - {last_dist_reg[31], last_dist_reg};
    assign corr_hit = $signed({dist_gap[32], dist_gap}) >= $signed({3'b0, step_reg});

    always_comb begin
        head_sum  = {heading_reg[14], heading_reg} + {dth_reg[14], dth_reg};
        head_wrap = head_sum;
        if (head_sum > PI_Q) begin
            head_wrap = head_sum - TWO_PI_Q;
        end else if (head_sum < -PI_Q) begin
            head_wrap = head_sum + TWO_PI_Q;
        end
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_M1: begin
                mul_a = {20'b0, radius_reg};
                mul_b = {4'b0, adiff_reg};
            end
            S_M2: begin
                mul_a = {4'b0, prod_reg[31:0]};
                mul_b = {4'b0, slip_reg};
            end
            S_ST1: begin
                mul_a = {20'b0, radius_reg};
                mul_b = 20'(sum_reg);
            end
            S_ST3: begin
                mul_a = 36'(dist_reg);
                mul_b = 20'(ch_reg);
            end
            S_ST4: begin
                mul_a = 36'(dist_reg);
                mul_b = 20'(sh_reg);
            end
            S_A1: begin
                mul_a = {20'b0, base_eff};
                mul_b = 20'(sum_reg);
            end
            S_A3: begin
                mul_a = 36'(n2_reg);
                mul_b = 20'(cor_sin);
            end
            S_A5: begin
                mul_a = 36'(n2_reg);
                mul_b = 20'sd65536 - 20'(cor_cos);
            end
            S_A7: begin
                mul_a = bx_reg;
                mul_b = 20'(ch_reg);
            end
            S_A8: begin
                mul_a = by_reg;
                mul_b = 20'(sh_reg);
            end
            S_A9: begin
                mul_a = bx_reg;
                mul_b = 20'(sh_reg);
            end
            S_A10: begin
                mul_a = by_reg;
                mul_b = 20'(ch_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        div_start  = 1'b0;
        div_num    = '0;
        div_den    = adiff_reg;
        cor_start  = 1'b0;
        cor_angle  = heading_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    cor_start  = !s_mode;
                    state_next = s_mode ? S_CORR : S_M1;
                end
            end
            S_M1:  state_next = S_M2;
            S_M2:  state_next = S_D1;
            S_D1: begin
                div_start  = 1'b1;
                div_num    = {4'b0, prod_reg[47:0]} + {21'b0, base_eff, 15'b0};
                div_den    = base_eff;
                state_next = S_D1W;
            end
            S_D1W: begin
                if (!div_busy && !cor_busy) begin
                    cor_start  = !straight;
                    cor_angle  = dth_w;
                    state_next = straight ? S_ST1 : S_A1;
                end
            end
            S_ST1: state_next = S_ST2;
            S_ST2: state_next = S_ST3;
            S_ST3: state_next = S_ST4;
            S_ST4: state_next = S_ST5;
            S_ST5: state_next = S_FIN;
            S_A1:  state_next = S_A2;
            S_A2:  state_next = S_A3;
            S_A3: begin
                if (!cor_busy) begin
                    state_next = S_A4;
                end
            end
            S_A4, S_A6: begin
                div_start  = 1'b1;
                div_num    = prod_abs[DIV_NUM_W-1:0] + {20'b0, adiff_reg, 16'b0};
                state_next = (state_reg == S_A4) ? S_A5 : S_A7;
            end
            S_A5: begin
                if (!div_busy) begin
                    state_next = S_A6;
                end
            end
            S_A7: begin
                if (!div_busy) begin
                    state_next = S_A8;
                end
            end
            S_A8:   state_next = S_A9;
            S_A9:   state_next = S_A10;
            S_A10:  state_next = S_A11;
            S_A11:  state_next = S_FIN;
            S_CORR: state_next = S_FIN;
            S_FIN: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    ddo_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .busy    (div_busy),
        .quot    (div_quot)
    );

    ddo_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cor_start),
        .angle   (cor_angle),
        .busy    (cor_busy),
        .cos_out (cor_cos),
        .sin_out (cor_sin)
    );

    // control and architectural state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            m_valid_reg   <= 1'b0;
            pose_x_reg    <= '0;
            pose_y_reg    <= '0;
            heading_reg   <= '0;
            last_dist_reg <= '0;
            seen_reg      <= 1'b0;
            radius_reg    <= 16'd2294;
            base_reg      <= 16'd13107;
            slip_reg      <= 16'd64881;
            thr_reg       <= 15'd41;
            step_reg      <= 31'd6554;
            drift_x_reg   <= 16'sd164;
            drift_y_reg   <= -16'sd38;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_FIN && out_free) begin
                m_valid_reg <= 1'b1;
                pose_x_reg  <= pose_x_reg + dx_reg;
                pose_y_reg  <= pose_y_reg + dy_reg;
                heading_reg <= head_wrap[14:0];
                if (hit_reg) begin
                    last_dist_reg <= cdist_reg;
                    seen_reg      <= 1'b1;
                end
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_WHEEL_RADIUS: radius_reg  <= cfg_wdata[15:0];
                    REG_WHEEL_BASE:   base_reg    <= cfg_wdata[15:0];
                    REG_SLIP_FACTOR:  slip_reg    <= cfg_wdata[15:0];
                    REG_STRAIGHT_THR: thr_reg     <= cfg_wdata[14:0];
                    REG_PATH_STEP:    step_reg    <= cfg_wdata;
                    REG_DRIFT_X:      drift_x_reg <= cfg_wdata[15:0];
                    REG_DRIFT_Y:      drift_y_reg <= cfg_wdata[15:0];
                    default: ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        prod_reg <= prod_w;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    diff_reg  <= {s_right_delta[15], s_right_delta}
                               - {s_left_delta[15], s_left_delta};
                    sum_reg   <= {s_right_delta[15], s_right_delta}
                               + {s_left_delta[15], s_left_delta};
                    adiff_reg <= (s_right_delta >= s_left_delta)
                               ? 16'(s_right_delta - s_left_delta)
                               : 16'(s_left_delta - s_right_delta);
                    cdist_reg <= s_centre_distance;
                    hit_reg   <= 1'b0;
                end
            end
            S_D1W: begin
                if (!div_busy && !cor_busy) begin
                    dth_reg <= dth_w;
                    ch_reg  <= cor_cos;
                    sh_reg  <= cor_sin;
                end
            end
            S_ST2: dist_reg <= 21'(rnd_shr(prod_reg, 13));
            S_ST4: dx_reg   <= 32'(rnd_shr(prod_reg, 16));
            S_ST5: dy_reg   <= 32'(rnd_shr(prod_reg, 16));
            S_A2:  n2_reg   <= diff_reg[16] ? 35'(-prod_reg) : 35'(prod_reg);
            S_A4, S_A6: neg_reg <= prod_reg[55];
            S_A5: begin
                if (!div_busy) begin
                    bx_reg <= qdiv17;
                end
            end
            S_A7: begin
                if (!div_busy) begin
                    by_reg <= qdiv17;
                end
            end
            S_A8:  t1_reg <= prod_reg;
            S_A9:  dx_reg <= 32'(rnd_shr(t1_reg - prod_reg, 16));
            S_A10: t1_reg <= prod_reg;
            S_A11: dy_reg <= 32'(rnd_shr(t1_reg + prod_reg, 16));
            S_CORR: begin
                dth_reg <= '0;
                hit_reg <= corr_hit;
                dx_reg  <= corr_hit ? 32'(drift_x_reg) : 32'sd0;
                dy_reg  <= corr_hit ? 32'(drift_y_reg) : 32'sd0;
            end
            default: ;
        endcase
    end

    assign m_valid         = m_valid_reg;
    assign m_pos_x         = pose_x_reg;
    assign m_pos_y         = pose_y_reg;
    assign m_heading       = heading_reg;
    assign m_was_corrected = seen_reg;

endmodule
